@@ hw/rtl/icdw_pkg.sv @@
// Shared types and constants for the I2C converter-code writer.
// Used by every module of the block but the queue; depends on nothing.
`timescale 1ns / 1ps

package icdw_pkg;

   // Configuration register indexes and their reset values.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEV_ADDR    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS = 2'd1;
   localparam logic [7:0] DEV_ADDR_RESET    = 8'h98;
   localparam logic [7:0] PHASE_TICKS_RESET = 8'h12;

   // Queue depths used as defaults by the top level.
   localparam int MID_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   // Byte slot layout: eight bits of two phases each, then the two ack phases.
   localparam logic [4:0] SLOT_LAST = 5'd17;
   localparam logic [1:0] BYTE_LAST = 2'd2;
   localparam logic [7:0] LOW_BYTE_MASK = 8'hfc;

   typedef struct packed {
      logic [7:0] phase_ticks;
      logic [7:0] dev_addr;
   } cfg_type;

   // A request after decoding, as it waits between front and back.
   typedef struct packed {
      logic       is_write;
      logic [7:0] code_hi_byte;
      logic [7:0] code_lo_byte;
      logic       sda_level;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [2:0] nack_mask;
      logic       rejected;
   } result_type;

endpackage

@@ hw/rtl/icdw_fifo.sv @@
// Small synchronous queue with push/full and pop/empty handshakes.
// Generic; no package dependency.
`timescale 1ns / 1ps

module icdw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/icdw_front.sv @@
// Front decode: sorts a request into tick or write and splits the code into bytes.
// Depends on icdw_pkg.
`timescale 1ns / 1ps

module icdw_front (
   input  logic             req_command,
   input  logic [9:0]       req_dac_code,
   input  logic             req_sda_level,
   output icdw_pkg::item_type item
);
   import icdw_pkg::*;

   always_comb begin
      item.is_write     = req_command;
      // Second byte carries the top four code bits, third the low six shifted up.
      item.code_hi_byte = {4'b0000, req_dac_code[9:6]};
      item.code_lo_byte = {req_dac_code[5:0], 2'b00} & LOW_BYTE_MASK;
      item.sda_level    = req_sda_level;
   end

endmodule

@@ hw/rtl/icdw_back.sv @@
// Frame engine: runs the bus phases of bus-free, start, three bytes with acks, and stop.
// Depends on icdw_pkg; takes decoded requests and produces one result each.
`timescale 1ns / 1ps

module icdw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  icdw_pkg::cfg_type    cfg,
   input  logic                 step,
   input  icdw_pkg::item_type   item,
   output icdw_pkg::result_type result
);
   import icdw_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_BUSFREE  = 7'b0000010,
      ST_START    = 7'b0000100,
      ST_BIT      = 7'b0001000,
      ST_STOP_LOW = 7'b0010000,
      ST_STOP_SCL = 7'b0100000,
      ST_STOP_REL = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] timer_ff, timer_in;
   logic [1:0] byte_idx_ff, byte_idx_in;
   logic [4:0] slot_ff, slot_in;
   logic [7:0] shift_ff, shift_in;
   logic [2:0] ack_ff, ack_in;
   logic [7:0] hi_byte_ff, hi_byte_in;
   logic [7:0] lo_byte_ff, lo_byte_in;
   logic [8:0] tick_sum;
   logic [7:0] limit;
   logic       phase_end;
   logic       done, rej;
   logic [1:0] levels;

   always_comb begin
      state_in    = state_ff;
      timer_in    = timer_ff;
      byte_idx_in = byte_idx_ff;
      slot_in     = slot_ff;
      shift_in    = shift_ff;
      ack_in      = ack_ff;
      hi_byte_in  = hi_byte_ff;
      lo_byte_in  = lo_byte_ff;
      done        = 1'b0;
      rej         = 1'b0;
      tick_sum    = {1'b0, timer_ff} + 9'd1;
      limit       = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
      phase_end   = (tick_sum >= {1'b0, limit});

      if (item.is_write) begin
         if (state_ff != ST_IDLE) begin
            rej = 1'b1;
         end else begin
            hi_byte_in  = item.code_hi_byte;
            lo_byte_in  = item.code_lo_byte;
            ack_in      = 3'b000;
            timer_in    = 8'd0;
            shift_in    = 8'd0;
            byte_idx_in = 2'd0;
            slot_in     = 5'd0;
            state_in    = ST_BUSFREE;
         end
      end else if (state_ff != ST_IDLE) begin
         if (phase_end) begin
            timer_in = 8'd0;
            unique case (state_ff)
               ST_IDLE: begin
               end
               ST_BUSFREE: begin
                  state_in = ST_START;
               end
               ST_START: begin
                  state_in    = ST_BIT;
                  byte_idx_in = 2'd0;
                  slot_in     = 5'd0;
                  shift_in    = cfg.dev_addr;
               end
               ST_BIT: begin
                  // The data bit moves on after its SCL-high phase.
                  if (!slot_ff[4] && slot_ff[0]) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                  end
                  if (slot_ff == SLOT_LAST) begin
                     if (item.sda_level) begin
                        ack_in = ack_ff | (3'b001 << byte_idx_ff);
                     end
                     if (byte_idx_ff == BYTE_LAST) begin
                        state_in = ST_STOP_LOW;
                     end else begin
                        byte_idx_in = byte_idx_ff + 2'd1;
                        slot_in     = 5'd0;
                        shift_in    = (byte_idx_ff == 2'd0) ? hi_byte_ff : lo_byte_ff;
                     end
                  end else begin
                     slot_in = slot_ff + 5'd1;
                  end
               end
               ST_STOP_LOW: begin
                  state_in = ST_STOP_SCL;
               end
               ST_STOP_SCL: begin
                  state_in = ST_STOP_REL;
               end
               ST_STOP_REL: begin
                  state_in = ST_IDLE;
                  done     = 1'b1;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end else begin
            timer_in = tick_sum[7:0];
         end
      end

      // Line levels follow the phase reached by this request; {SCL, SDA}.
      unique case (state_in)
         ST_IDLE, ST_BUSFREE, ST_STOP_REL: levels = 2'b11;
         ST_START, ST_STOP_SCL:            levels = 2'b10;
         ST_STOP_LOW:                      levels = 2'b00;
         ST_BIT: levels = {slot_in[0], slot_in[4] ? 1'b1 : shift_in[7]};
         default:                          levels = 2'b11;
      endcase

      result.scl_out   = levels[1];
      result.sda_out   = levels[0];
      result.busy_res  = (state_in != ST_IDLE);
      result.done_res  = done;
      result.nack_mask = ack_in;
      result.rejected  = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         timer_ff    <= 8'd0;
         byte_idx_ff <= 2'd0;
         slot_ff     <= 5'd0;
         ack_ff      <= 3'b000;
      end else if (step) begin
         state_ff    <= state_in;
         timer_ff    <= timer_in;
         byte_idx_ff <= byte_idx_in;
         slot_ff     <= slot_in;
         ack_ff      <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         shift_ff   <= shift_in;
         hi_byte_ff <= hi_byte_in;
         lo_byte_ff <= lo_byte_in;
      end
   end

endmodule

@@ hw/rtl/i2c_dac_code_writer_top.sv @@
// Top level of the I2C converter-code writer: config registers, front decode,
// request queue, frame engine and result queue. Depends on icdw_pkg and all icdw_ modules.
//
//   Channel   Handshake          Payload
//   request   push / full        req_command, req_dac_code, req_sda_level
//   result    pop / empty        rsp_scl_out, rsp_sda_out, rsp_busy_res,
//                                rsp_done_res, rsp_nack_mask, rsp_rejected
//   config    csr_we             csr_index, csr_wdata
//
// The block takes one request per clock while full is low and returns one
// result per request. A request waits in the request queue until the frame engine
// processes it; the result is registered in the result queue, whose head drives the ports.
// The single frame engine step (one timer add and compare per request) sets the rate.
// Reset is synchronous and active high; it empties both queues and puts the
// engine and the config registers to their reset values.
// A held-off pop fills the result queue, the engine then stops, and full rises
// once the request queue is also full; each side stalls on its own.
`timescale 1ns / 1ps

module i2c_dac_code_writer_top #(
   parameter int MID_DEPTH = icdw_pkg::MID_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = icdw_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_command,
   input  logic [9:0]                       req_dac_code,
   input  logic                             req_sda_level,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_scl_out,
   output logic                             rsp_sda_out,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [2:0]                       rsp_nack_mask,
   output logic                             rsp_rejected,
   input  logic                             csr_we,
   input  logic [icdw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import icdw_pkg::*;

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

   logic [7:0] dev_addr_ff, dev_addr_in;
   logic [7:0] phase_ticks_ff, phase_ticks_in;
   cfg_type    cfg;
   item_type   front_item;
   item_type   mid_item;
   logic       mid_empty;
   logic       rsp_full;
   logic       step;
   result_type back_result;
   result_type rsp_result;

   // Config registers: the user writes only while no request is in flight; not enforced.
   always_comb begin
      dev_addr_in    = dev_addr_ff;
      phase_ticks_in = phase_ticks_ff;
      if (csr_we) begin
         if (csr_index == CSR_DEV_ADDR) begin
            dev_addr_in = csr_wdata;
         end else if (csr_index == CSR_PHASE_TICKS) begin
            phase_ticks_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEV_ADDR_RESET;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         dev_addr_ff    <= dev_addr_in;
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   assign cfg.dev_addr    = dev_addr_ff;
   assign cfg.phase_ticks = phase_ticks_ff;

   icdw_front u_front (
      .req_command   (req_command),
      .req_dac_code  (req_dac_code),
      .req_sda_level (req_sda_level),
      .item          (front_item)
   );

   icdw_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (step),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   // The engine advances only when a request waits and its result has room.
   assign step = !mid_empty && !rsp_full;

   icdw_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .item   (mid_item),
      .result (back_result)
   );

   icdw_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (back_result),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_result),
      .empty     (empty)
   );

   assign rsp_scl_out   = rsp_result.scl_out;
   assign rsp_sda_out   = rsp_result.sda_out;
   assign rsp_busy_res  = rsp_result.busy_res;
   assign rsp_done_res  = rsp_result.done_res;
   assign rsp_nack_mask = rsp_result.nack_mask;
   assign rsp_rejected  = rsp_result.rejected;

   // A finished frame is never reported as still busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_done_res) |-> !rsp_busy_res)
      else $error("done result reported while busy");

   // A dropped write can only happen during a frame.
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_rejected) |-> rsp_busy_res)
      else $error("write rejected while idle");

   // A stalled engine keeps its pending request in place.
   a_engine_stall: assert property (@(posedge clock) disable iff (reset)
      (!mid_empty && rsp_full) |=> !mid_empty)
      else $error("request lost while the result queue was full");

   // Reset leaves both queues empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule

@@ sim/i2c_dac_code_writer_check.sv @@
// Request/result monitor for the I2C converter-code writer: predicts every result
// from the accepted requests and compares it field by field. Depends on icdw_pkg.
`timescale 1ns / 1ps

module i2c_dac_code_writer_check
   import icdw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic                   req_command,
   input  logic [9:0]             req_dac_code,
   input  logic                   req_sda_level,
   input  logic                   empty,
   input  logic                   pop,
   input  logic                   rsp_scl_out,
   input  logic                   rsp_sda_out,
   input  logic                   rsp_busy_res,
   input  logic                   rsp_done_res,
   input  logic [2:0]             rsp_nack_mask,
   input  logic                   rsp_rejected,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   // Frame layout: bus-free hold, start, three byte slots, stop low, stop high, release.
   localparam int PH_IDLE      = 0;
   localparam int PH_FIRST     = 1;
   localparam int PH_START     = 2;
   localparam int PH_BYTE0     = 3;
   localparam int SLOT_PHASES  = 18;
   localparam int DATA_PHASES  = 16;
   localparam int BYTE_PHASES  = 3 * SLOT_PHASES;
   localparam int PH_STOP_LOW  = 57;
   localparam int PH_STOP_HIGH = 58;
   localparam int PH_LAST      = 59;

   logic [7:0] addr_q;
   logic [7:0] ticks_q;
   logic [6:0] phase_q;
   logic [7:0] timer_q;
   logic [9:0] code_q;
   logic [7:0] shift_q;
   logic [2:0] nack_q;

   result_type due_results[$];
   int errs = 0;

   function automatic logic [7:0] byte_for(int idx);
      case (idx)
         0:       return addr_q;
         1:       return 8'(code_q >> 6);
         default: return 8'(code_q << 2) & LOW_BYTE_MASK;
      endcase
   endfunction

   // Bit 1 is SCL, bit 0 is SDA.
   function automatic logic [1:0] line_levels_for(int p);
      int r;
      if (p <= PH_FIRST) return 2'b11;
      if (p == PH_START) return 2'b10;
      if (p >= PH_BYTE0 && p < PH_BYTE0 + BYTE_PHASES) begin
         r = (p - PH_BYTE0) % SLOT_PHASES;
         return {r[0], (r >= DATA_PHASES) ? 1'b1 : shift_q[7]};
      end
      if (p == PH_STOP_LOW) return 2'b00;
      if (p == PH_STOP_HIGH) return 2'b10;
      return 2'b11;
   endfunction

   function automatic void close_phase(logic sda);
      int p;
      int q;
      int r;
      p = phase_q;
      if (p >= PH_BYTE0 && p < PH_BYTE0 + BYTE_PHASES) begin
         q = p - PH_BYTE0;
         r = q % SLOT_PHASES;
         if (r < DATA_PHASES && r[0]) shift_q = shift_q << 1;
         // The acknowledge is sampled at the end of the slot's SCL-high phase.
         if (r == SLOT_PHASES - 1 && sda) nack_q[q / SLOT_PHASES] = 1'b1;
      end
      if (p >= PH_LAST) begin
         phase_q = 7'(PH_IDLE);
         return;
      end
      p++;
      phase_q = 7'(p);
      if (p >= PH_BYTE0 && p < PH_BYTE0 + BYTE_PHASES && (p - PH_BYTE0) % SLOT_PHASES == 0)
         shift_q = byte_for((p - PH_BYTE0) / SLOT_PHASES);
   endfunction

   function automatic result_type advance_frame(logic is_write, logic [9:0] code, logic sda);
      result_type res;
      int limit;
      int t;
      logic [1:0] lv;
      res = '0;
      limit = (ticks_q == 0) ? 1 : int'(ticks_q);
      if (is_write) begin
         if (phase_q != PH_IDLE) begin
            res.rejected = 1'b1;
         end else begin
            code_q  = code;
            nack_q  = '0;
            timer_q = '0;
            shift_q = '0;
            phase_q = 7'(PH_FIRST);
         end
      end else if (phase_q != PH_IDLE) begin
         t = int'(timer_q) + 1;
         if (t >= limit) begin
            timer_q = '0;
            close_phase(sda);
            if (phase_q == PH_IDLE) res.done_res = 1'b1;
         end else begin
            timer_q = 8'(t);
         end
      end
      lv = (phase_q == PH_IDLE) ? 2'b11 : line_levels_for(phase_q);
      res.scl_out   = lv[1];
      res.sda_out   = lv[0];
      res.busy_res  = (phase_q != PH_IDLE);
      res.nack_mask = nack_q;
      return res;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         addr_q  = DEV_ADDR_RESET;
         ticks_q = PHASE_TICKS_RESET;
         phase_q = 7'(PH_IDLE);
         timer_q = '0;
         code_q  = '0;
         shift_q = '0;
         nack_q  = '0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEV_ADDR:    addr_q = csr_wdata;
               CSR_PHASE_TICKS: ticks_q = csr_wdata;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (due_results.size() == 0) begin
               $error("result arrived with no request waiting");
               errs++;
            end else begin
               want = due_results.pop_front();
               compare_field("scl_out", want.scl_out, rsp_scl_out);
               compare_field("sda_out", want.sda_out, rsp_sda_out);
               compare_field("busy_res", want.busy_res, rsp_busy_res);
               compare_field("done_res", want.done_res, rsp_done_res);
               compare_field("nack_mask", want.nack_mask, rsp_nack_mask);
               compare_field("rejected", want.rejected, rsp_rejected);
            end
         end
         if (push && !full)
            due_results.push_back(advance_frame(req_command, req_dac_code, req_sda_level));
      end
      fail_count  <= errs;
      outstanding <= due_results.size();
   end

endmodule

@@ sim/tb_i2c_dac_code_writer_top.sv @@
// Testbench top for the I2C converter-code writer: clock, reset, request and
// config stimulus, result draining and the verdict. Depends on icdw_pkg,
// i2c_dac_code_writer_top and i2c_dac_code_writer_check.
`timescale 1ns / 1ps

module tb_i2c_dac_code_writer_top;
   import icdw_pkg::*;

   // Request kinds carried on req_command.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // A frame is 59 line phases; the first acknowledge is sampled at the end of
   // phase 20 and the next ones one byte slot (18 phases) later each.
   localparam int FRAME_PHASES    = 59;
   localparam int ACK_FIRST_PHASE = 20;
   localparam int SLOT_PHASES     = 18;

   localparam int RANDOM_REQUESTS = 150;
   localparam int FINAL_TICKS     = 520;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_AFTER  = 600;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1000000;

   // First register index past the implemented ones; writes there are ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = CSR_PHASE_TICKS + 1'b1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   req_command = CMD_TICK;
   logic [9:0]             req_dac_code = '0;
   logic                   req_sda_level = 1'b0;
   logic                   pop = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEV_ADDR;
   logic [7:0]             csr_wdata = '0;

   logic       full;
   logic       empty;
   logic       rsp_scl_out;
   logic       rsp_sda_out;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [2:0] rsp_nack_mask;
   logic       rsp_rejected;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int requests_sent = 0;

   // When set, neither side inserts gaps, so the block runs at full rate.
   bit steady = 1'b0;

   i2c_dac_code_writer_top dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_command   (req_command),
      .req_dac_code  (req_dac_code),
      .req_sda_level (req_sda_level),
      .empty         (empty),
      .pop           (pop),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_nack_mask (rsp_nack_mask),
      .rsp_rejected  (rsp_rejected),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // The monitor sees exactly the ports the block sees and keeps its own model.
   i2c_dac_code_writer_check frame_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A correct run ends far below this count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Idle gap length shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 20);
      return $urandom_range(30, 80);
   endfunction

   // Offers one request and returns at the edge where it is accepted. Push stays
   // high afterwards so that back-to-back requests need no extra assignment.
   task automatic send_request(logic cmd, logic [9:0] code, logic sda);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_command   <= cmd;
      req_dac_code  <= code;
      req_sda_level <= sda;
      do @(posedge clock); while (full);
      requests_sent++;
   endtask

   // The code field of a tick is don't-care, so it carries random bits.
   task automatic send_tick(logic sda);
      send_request(CMD_TICK, 10'($urandom), sda);
   endtask

   // Stops offering requests and waits until every result has come back,
   // then lets the pipeline settle before anything touches the registers.
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers and then one unused index with random data.
   task automatic set_config(logic [7:0] addr, logic [7:0] ticks);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEV_ADDR;
      csr_wdata <= addr;
      @(posedge clock);
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_index <= CSR_SPARE | CSR_INDEX_W'($urandom_range(0, 1));
      csr_wdata <= 8'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Starts a frame with a write request and then feeds tick_total ticks. The
   // line level on the tick that closes each acknowledge slot comes from
   // ack_miss, so the nack mask is steered; all other ticks carry random levels.
   // noise_pct of the requests are extra writes that land while busy and must
   // be dropped without moving the frame.
   task automatic run_frame(logic [9:0] code, int limit, int tick_total, int noise_pct,
                            logic [2:0] ack_miss);
      int ticked;
      int n;
      int p;
      logic sda;
      send_request(CMD_WRITE, code, 1'($urandom));
      ticked = 0;
      while (ticked < tick_total) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_request(CMD_WRITE, 10'($urandom), 1'($urandom));
         end else begin
            n = ticked + 1;
            p = n / limit;
            sda = 1'($urandom);
            if (n % limit == 0 && p >= ACK_FIRST_PHASE &&
                (p - ACK_FIRST_PHASE) % SLOT_PHASES == 0)
               sda = ack_miss[(p - ACK_FIRST_PHASE) / SLOT_PHASES];
            send_tick(sda);
            ticked++;
         end
      end
   endtask

   // Result side: pops in runs of random length with gaps between them. Once,
   // after the run is well under way, pop is held low for a long stretch while
   // the sender keeps offering requests, so both queues fill and full rises.
   initial begin : result_drain
      int run;
      int gap;
      bit held_off;
      held_off = 1'b0;
      wait (!reset);
      forever begin
         pop <= 1'b1;
         run = $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (!held_off && cycle_count > HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            gap = HOLD_OFF_CYCLES;
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] ticks;
      logic [9:0] code;
      int lim;
      int goal;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Ticks while idle must leave the lines released and nothing busy.
      repeat (3) send_tick(1'($urandom));

      // The opening frame runs under the reset register values until the address
      // byte and its acknowledge are out, so the reset device address goes out and
      // each of those phases lasts the reset tick count. The rest of the frame then
      // runs at one tick per phase, and enough ticks follow to reach idle again.
      run_frame(10'($urandom), PHASE_TICKS_RESET,
                (ACK_FIRST_PHASE + 1) * PHASE_TICKS_RESET, 2, 3'($urandom));
      drain();
      set_config(DEV_ADDR_RESET, 8'h01);
      repeat (FRAME_PHASES) send_tick(1'($urandom));
      send_tick(1'b0);
      send_tick(1'b1);
      drain();

      // A phase length of zero must behave as one tick. Largest code, address
      // of all zeros, and no byte acknowledged.
      set_config(8'h00, 8'h00);
      run_frame(10'h3ff, 1, FRAME_PHASES, 5, 3'b111);
      repeat (2) send_tick(1'($urandom));
      drain();

      // Smallest code, address of all ones, every byte acknowledged.
      set_config(8'hff, 8'h01);
      run_frame(10'h000, 1, FRAME_PHASES, 5, 3'b000);
      drain();

      // Random part: sessions of one to three frames with short phases, random
      // addresses and codes, random acknowledge patterns and dropped writes.
      goal = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 40) ticks = 8'd1;
         else if (r < 60) ticks = 8'd0;
         else if (r < 80) ticks = 8'd2;
         else ticks = 8'($urandom_range(3, 6));
         lim = (ticks == 0) ? 1 : int'(ticks);
         steady = ($urandom_range(0, 3) == 0);
         set_config(8'($urandom), ticks);
         repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom));
            r = $urandom_range(0, 9);
            if (r == 0) code = 10'h000;
            else if (r == 1) code = 10'h3ff;
            else code = 10'($urandom);
            run_frame(code, lim, FRAME_PHASES * lim, 5, 3'($urandom));
         end
         drain();
      end
      steady = 1'b0;

      // Longest phase length last: only the first few phases of this frame are
      // run, enough for the phase timer to count all the way up twice.
      set_config(8'($urandom), 8'hff);
      run_frame(10'($urandom), 255, FINAL_TICKS, 3, 3'($urandom));
      drain();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/icdw_pkg.sv
hw/rtl/icdw_fifo.sv
hw/rtl/icdw_front.sv
hw/rtl/icdw_back.sv
hw/rtl/i2c_dac_code_writer_top.sv
sim/i2c_dac_code_writer_check.sv
sim/tb_i2c_dac_code_writer_top.sv
